[sv/fstm_pkg.sv]
// Shared types, constants and the arctangent table for the fixed-step mover.
`default_nettype none

package fstm_pkg;

  // Default values of the top-level parameters
  localparam int DEF_VIEW_WIDTH   = 800;
  localparam int DEF_VIEW_HEIGHT  = 600;
  localparam int DEF_FRAC_BITS    = 8;
  localparam int DEF_CORDIC_STEPS = 16;

  // Fixed field widths
  localparam int STEP_W = 16;
  localparam int SCR_W  = 10;
  localparam int TGT_W  = 11;
  localparam int POS_W  = 19;
  localparam int HEAD_W = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd2560;
  localparam int POS_MAX = 262143;
  localparam int POS_MIN = -262144;

  // CORDIC constants: angles in Q.30 radians, 16 guard bits on the vectors
  localparam int GUARD   = 16;
  localparam int ANG_FRAC = 30;
  localparam int ZW      = 34;
  localparam int ATAN_W  = 30;
  localparam int TBL_W   = 5;
  localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
  localparam logic [ATAN_W-1:0]    KINV_Q30 = 30'd652032874;

  // Heading = round(|z| * 25600 / 3.14 / 2^30), reduced to
  // floor(((|z| * 625 + 157 * 2^18) >> 19) / 157)
  localparam int HMW          = ZW + 10;
  localparam int HM_SHIFT     = 19;
  localparam int QW           = HMW - HM_SHIFT;
  localparam int MUL_C        = 625;
  localparam int DIV_C        = 157;
  localparam logic [HMW-1:0] HM_OFS = HMW'(157 * (2 ** 18));
  localparam int RW           = 25;
  localparam logic [RW-1:0] RECIP_157 = 25'd27356479;
  localparam int RECIP_SHIFT  = 32;
  localparam int HPW          = QW + RW;
  localparam int QEW          = HPW - RECIP_SHIFT;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_TARGET,
    OP_TICK,
    OP_SQ_DX,
    OP_SQ_DY,
    OP_SQ_ST,
    OP_SNAP,
    OP_ZERO,
    OP_INIT,
    OP_ITER,
    OP_ROUND,
    OP_MOVE,
    OP_HMUL,
    OP_HQ,
    OP_HREM,
    OP_HFIN,
    OP_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_DX,
    S_SQ_DY,
    S_SQ_ST,
    S_CMP,
    S_SNAP,
    S_ZERO,
    S_INIT,
    S_ITER,
    S_ROUND,
    S_MOVE,
    S_HMUL,
    S_HQ,
    S_HREM,
    S_HFIN,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [TBL_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic snap;
    logic zero;
  } sts_t;

  // atan(2^-i) in Q.30 radians
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [TBL_W-1:0] i);
    case (i)
      5'd0:    return 30'd843314857;
      5'd1:    return 30'd497837829;
      5'd2:    return 30'd263043837;
      5'd3:    return 30'd133525159;
      5'd4:    return 30'd67021687;
      5'd5:    return 30'd33543516;
      5'd6:    return 30'd16775851;
      5'd7:    return 30'd8388437;
      5'd8:    return 30'd4194283;
      5'd9:    return 30'd2097149;
      5'd10:   return 30'd1048576;
      5'd11:   return 30'd524288;
      5'd12:   return 30'd262144;
      5'd13:   return 30'd131072;
      5'd14:   return 30'd65536;
      5'd15:   return 30'd32768;
      5'd16:   return 30'd16384;
      5'd17:   return 30'd8192;
      5'd18:   return 30'd4096;
      5'd19:   return 30'd2048;
      5'd20:   return 30'd1024;
      5'd21:   return 30'd512;
      5'd22:   return 30'd256;
      5'd23:   return 30'd128;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/fixed_step_move_to_target.sv]
// Top level of the fixed-step mover: controller, datapath and config port.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_type, screen_x, screen_y
//   out      output     out_valid / out_stall out_x, out_y, out_heading, arrived
//   cfg      input      cfg_valid / cfg_ready cfg_data (step_length)
//
// A pointer event only records the target; a tick squares dx, dy and the step length,
// then snaps, zeroes the heading at zero distance or, when it moves, runs CORDIC_STEPS
// micro-rotations at one per cycle in the CORDIC loop and then scales the heading.
// The next item is taken the cycle after the result is loaded into the output register.
// Reset clears position, target and heading and sets step_length to 2560.
// A stalled result holds in the output register; the block works on the next
// item and waits only when that item's result is ready.
`default_nettype none

module fixed_step_move_to_target import fstm_pkg::*; #(
  parameter int VIEW_WIDTH   = DEF_VIEW_WIDTH,
  parameter int VIEW_HEIGHT  = DEF_VIEW_HEIGHT,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                req_type,
  input  wire logic [SCR_W-1:0]    screen_x,
  input  wire logic [SCR_W-1:0]    screen_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [POS_W-1:0]  out_x,
  output logic signed [POS_W-1:0]  out_y,
  output logic signed [HEAD_W-1:0] out_heading,
  output logic                     arrived,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [STEP_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // The user must write only while idle; the block does not enforce it and always takes writes
  assign cfg_ready = 1'b1;

  fstm_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fstm_dp #(
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_heading (out_heading),
    .arrived     (arrived)
  );

endmodule

`default_nettype wire

[sv/fstm_ctrl.sv]
// Sequencing state machine for the fixed-step mover.
`default_nettype none

module fstm_ctrl import fstm_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic req_type,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [TBL_W-1:0] LAST = TBL_W'(CORDIC_STEPS - 1);

  state_t           state, state_next;
  logic [TBL_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             free;

  assign free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = req_type ? S_SQ_DX : S_DONE;
        end
      end
      S_SQ_DX: state_next = S_SQ_DY;
      S_SQ_DY: state_next = S_SQ_ST;
      S_SQ_ST: state_next = S_CMP;
      S_CMP: begin
        if (sts.snap) begin
          state_next = S_SNAP;
        end else if (sts.zero) begin
          state_next = S_ZERO;
        end else begin
          state_next = S_INIT;
        end
      end
      S_SNAP:  state_next = S_DONE;
      S_ZERO:  state_next = S_DONE;
      S_INIT:  state_next = S_ITER;
      S_ITER: begin
        if (cnt == LAST) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: state_next = S_MOVE;
      S_MOVE:  state_next = S_HMUL;
      S_HMUL:  state_next = S_HQ;
      S_HQ:    state_next = S_HREM;
      S_HREM:  state_next = S_HFIN;
      S_HFIN:  state_next = S_DONE;
      S_DONE: begin
        if (free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: datapath command, input stall, iteration count
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idx  = cnt;
    cnt_next = cnt;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = req_type ? OP_TICK : OP_TARGET;
        end
      end
      S_SQ_DX: cmd.op = OP_SQ_DX;
      S_SQ_DY: cmd.op = OP_SQ_DY;
      S_SQ_ST: cmd.op = OP_SQ_ST;
      S_SNAP:  cmd.op = OP_SNAP;
      S_ZERO:  cmd.op = OP_ZERO;
      S_INIT: begin
        cmd.op   = OP_INIT;
        cnt_next = '0;
      end
      S_ITER: begin
        cmd.op   = OP_ITER;
        cnt_next = cnt + 1'b1;
      end
      S_ROUND: cmd.op = OP_ROUND;
      S_MOVE:  cmd.op = OP_MOVE;
      S_HMUL:  cmd.op = OP_HMUL;
      S_HQ:    cmd.op = OP_HQ;
      S_HREM:  cmd.op = OP_HREM;
      S_HFIN:  cmd.op = OP_HFIN;
      S_DONE: begin
        if (free) begin
          cmd.op = OP_LOAD;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  // Hold a result until its transfer, load a new one when free
  always_comb begin
    if (state == S_DONE && free) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[sv/fstm_dp.sv]
// Datapath: target, snap test, CORDIC vectoring/rotation, heading scaling.
`default_nettype none

module fstm_dp import fstm_pkg::*; #(
  parameter int VIEW_WIDTH  = DEF_VIEW_WIDTH,
  parameter int VIEW_HEIGHT = DEF_VIEW_HEIGHT,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               cfg_valid,
  input  wire logic [STEP_W-1:0]  cfg_data,
  input  wire logic [SCR_W-1:0]   screen_x,
  input  wire logic [SCR_W-1:0]   screen_y,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic signed [HEAD_W-1:0] out_heading,
  output logic                    arrived
);

  localparam int TXW = TGT_W + FRAC_BITS;
  localparam int DW  = ((TXW > POS_W) ? TXW : POS_W) + 1;
  localparam int PW  = 2 * DW;
  localparam int AW  = PW + 1;
  localparam int SW  = FRAC_BITS + 8;
  localparam int XW  = DW + GUARD + 2;
  localparam int UW  = SW + GUARD + 2;
  localparam int DDW = UW - GUARD;
  localparam int KPW = SW + ATAN_W;

  localparam logic [TGT_W-1:0] HALF_W = TGT_W'(VIEW_WIDTH / 2);
  localparam logic [TGT_W-1:0] HALF_H = TGT_W'(VIEW_HEIGHT / 2);
  localparam logic signed [DW-1:0] SAT_HI = DW'(POS_MAX);
  localparam logic signed [DW-1:0] SAT_LO = DW'(POS_MIN);
  localparam logic signed [UW-1:0] RND0 = UW'(2 ** (GUARD - 1));
  localparam logic signed [UW-1:0] RND1 = UW'(2 ** (GUARD - 1) + 1);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[POS_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  // Architectural state
  logic [STEP_W-1:0]        step_length;
  logic signed [POS_W-1:0]  pos_x, pos_y;
  logic signed [TGT_W-1:0]  tgt_x, tgt_y;
  logic signed [HEAD_W-1:0] heading;
  logic                     arrived_f;

  // Working registers
  logic signed [DW-1:0]  dx, dy;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  acc;
  logic signed [XW-1:0]  x, y;
  logic signed [ZW-1:0]  z;
  logic signed [UW-1:0]  u, v;
  logic                  fold;
  logic signed [DDW-1:0] du, dv;
  logic [ZW-1:0]         zmag;
  logic                  zneg;
  logic [HMW-1:0]        hm;
  logic [HPW-1:0]        hp;
  logic [QEW-1:0]        qe;
  logic [QW-1:0]         hr;

  // Combinational helpers
  logic [STEP_W+7:0]        step_wide;
  logic [SW-1:0]            step_sc;
  logic signed [TXW-1:0]    tx_x, tx_y;
  logic signed [DW-1:0]     mop;
  logic [KPW-1:0]           kprod;
  logic signed [XW-1:0]     xi, yi, xs, ys;
  logic signed [UW-1:0]     us, vs, ur, vr;
  logic signed [ZW-1:0]     at;
  logic                     fold_c;
  logic [QW-1:0]            hq;
  logic [HEAD_W-1:0]        hsum;

  // Step length rescaled from Q8.8 to the position format
  assign step_wide = {step_length, 8'h00};
  assign step_sc   = SW'(step_wide >> (16 - FRAC_BITS));

  assign tx_x = $signed({tgt_x, {FRAC_BITS{1'b0}}});
  assign tx_y = $signed({tgt_y, {FRAC_BITS{1'b0}}});

  // Squarer operand select
  always_comb begin
    case (cmd.op)
      OP_SQ_DX: mop = dx;
      OP_SQ_DY: mop = dy;
      default:  mop = $signed(DW'(step_sc));
    endcase
  end

  // Status back to the controller
  assign sts.snap = (acc < AW'(prod));
  assign sts.zero = (dx == '0) && (dy == '0);

  // CORDIC start values: fold the left half plane onto the right
  assign fold_c = dx[DW-1];
  assign xi     = XW'(dx) <<< GUARD;
  assign yi     = XW'(dy) <<< GUARD;
  assign kprod  = KPW'(step_sc) * KPW'(KINV_Q30);

  // Micro-rotation terms
  assign xs = x >>> cmd.idx;
  assign ys = y >>> cmd.idx;
  assign us = u >>> cmd.idx;
  assign vs = v >>> cmd.idx;
  assign at = $signed({{(ZW - ATAN_W){1'b0}}, atan_q30(cmd.idx)});

  // Round deltas to nearest, ties up; undo the fold as ~u + 1
  assign ur = (fold ? ~u : u) + (fold ? RND1 : RND0);
  assign vr = (fold ? ~v : v) + (fold ? RND1 : RND0);

  assign hq   = hm[HMW-1:HM_SHIFT];
  assign hsum = HEAD_W'(qe) + HEAD_W'(hr >= QW'(DIV_C));

  // Configuration register and state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_RESET;
      pos_x       <= '0;
      pos_y       <= '0;
      tgt_x       <= '0;
      tgt_y       <= '0;
      heading     <= '0;
    end else begin
      if (cfg_valid) begin
        step_length <= cfg_data;
      end
      case (cmd.op)
        OP_TARGET: begin
          tgt_x <= $signed({1'b0, screen_x} - HALF_W);
          tgt_y <= $signed(HALF_H - {1'b0, screen_y});
        end
        OP_SNAP: begin
          pos_x <= sat_pos(DW'(tx_x));
          pos_y <= sat_pos(DW'(tx_y));
        end
        OP_ZERO: heading <= '0;
        OP_MOVE: begin
          pos_x <= sat_pos(DW'(pos_x) + DW'(du));
          pos_y <= sat_pos(DW'(pos_y) + DW'(dv));
        end
        OP_HFIN: heading <= zneg ? -$signed(hsum) : $signed(hsum);
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TARGET: arrived_f <= 1'b0;
      OP_TICK: begin
        arrived_f <= 1'b0;
        dx        <= DW'(tx_x) - DW'(pos_x);
        dy        <= DW'(tx_y) - DW'(pos_y);
      end
      OP_SQ_DX: prod <= mop * mop;
      OP_SQ_DY: begin
        prod <= mop * mop;
        acc  <= AW'(prod);
      end
      OP_SQ_ST: begin
        prod <= mop * mop;
        acc  <= acc + AW'(prod);
      end
      OP_SNAP: arrived_f <= 1'b1;
      OP_INIT: begin
        fold <= fold_c;
        x    <= fold_c ? -xi : xi;
        y    <= fold_c ? -yi : yi;
        if (!fold_c) begin
          z <= '0;
        end else begin
          z <= dy[DW-1] ? -PI_Q30 : PI_Q30;
        end
        u <= $signed(UW'(kprod >> (ANG_FRAC - GUARD)));
        v <= '0;
      end
      OP_ITER: begin
        // Drive y toward zero and rotate the step vector the same way
        if (!y[XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
          u <= u - vs;
          v <= v + us;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
          u <= u + vs;
          v <= v - us;
        end
      end
      OP_ROUND: begin
        du   <= ur[UW-1:GUARD];
        dv   <= vr[UW-1:GUARD];
        zneg <= z[ZW-1];
        zmag <= z[ZW-1] ? -z : z;
      end
      OP_MOVE: hm   <= HMW'(zmag) * HMW'(MUL_C) + HM_OFS;
      OP_HMUL: hp   <= HPW'(hq) * HPW'(RECIP_157);
      OP_HQ:   qe   <= hp[HPW-1:RECIP_SHIFT];
      OP_HREM: hr   <= hq - QW'(QW'(qe) * QW'(DIV_C));
      OP_LOAD: begin
        out_x       <= pos_x;
        out_y       <= pos_y;
        out_heading <= heading;
        arrived     <= arrived_f;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
